// ----- rtl/xtea_pkg.sv -----
// Shared types, constants and the round mixing function for the XTEA encrypt block.
// No dependencies; imported by every module under rtl/.
package xtea_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned NUM_KEY_WORDS = 4;
  localparam int unsigned KEY_IDX_W     = $clog2(NUM_KEY_WORDS);
  localparam int unsigned ROUNDS_DEFAULT = 32;
  localparam int unsigned KEY_SEL_SHIFT = 11;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // One beat moving down the cell chain
  typedef struct packed {
    logic  valid;
    word_t v0;
    word_t v1;
  } beat_t;

  function automatic word_t mix(input word_t v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ----- rtl/xtea_key_regs.sv -----
// Key register bank: four 32-bit key words written through the config port.
// Depends on xtea_pkg.
module xtea_key_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [xtea_pkg::KEY_IDX_W-1:0] write_index,
  input  xtea_pkg::word_t               write_data,
  output xtea_pkg::key_t                key
);
  import xtea_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (write_enable) begin
      key[write_index] <= write_data;
    end
  end

endmodule

// ----- rtl/xtea_cell.sv -----
// One half-round of XTEA: even cells update v0, odd cells update v1.
// Depends on xtea_pkg; instantiated in a chain by xtea_encrypt_block.
module xtea_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  xtea_pkg::key_t  key,
  input  xtea_pkg::beat_t prev,
  output xtea_pkg::beat_t cur
);
  import xtea_pkg::*;

  // Round sum seen by this half: r*delta for the v0 half, (r+1)*delta for the v1 half
  localparam logic [63:0] SUM_WIDE = 64'((CELL_INDEX + 1) / 2) * 64'(DELTA);
  localparam word_t       SUM      = SUM_WIDE[WORD_W-1:0];
  localparam bit          UPPER    = (CELL_INDEX % 2) == 1;
  localparam logic [KEY_IDX_W-1:0] SEL =
      UPPER ? SUM[KEY_SEL_SHIFT +: KEY_IDX_W] : SUM[KEY_IDX_W-1:0];

  word_t addend;
  beat_t cur_next;

  assign addend = SUM + key[SEL];

  always_comb begin
    cur_next = prev;
    if (UPPER) begin
      cur_next.v1 = prev.v1 + (mix(prev.v0) ^ addend);
    end else begin
      cur_next.v0 = prev.v0 + (mix(prev.v1) ^ addend);
    end
  end

  // Only the valid bit is reset; data simply follows the chain
  always_ff @(posedge clk) begin
    if (advance) begin
      cur.v0 <= cur_next.v0;
      cur.v1 <= cur_next.v1;
    end
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (advance) begin
      cur.valid <= cur_next.valid;
    end
  end

endmodule

// ----- rtl/xtea_encrypt_block.sv -----
// XTEA encryption top level: key registers and a chain of 2*ROUNDS half-round cells.
// Depends on xtea_pkg, xtea_key_regs and xtea_cell.
//
//   channel  handshake                  payload
//   seed     seed_valid / seed_stall    seed_high, seed_low
//   result   result_valid / result_stall key_high, key_low
//   config   write_enable               write_index, write_data
//
// One beat enters per cycle unless the chain holds; each beat passes through all 2*ROUNDS
// cells of the chain, one half-round per cell, and the last cell is the output register.
// The chain moves as a whole: it holds, and seed_stall rises, only while a finished
// result is stalled. Synchronous reset clears the valid bits and the key words.
module xtea_encrypt_block #(
  parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seed_valid,
  output logic                          seed_stall,
  input  xtea_pkg::word_t               seed_high,
  input  xtea_pkg::word_t               seed_low,
  output logic                          result_valid,
  input  logic                          result_stall,
  output xtea_pkg::word_t               key_high,
  output xtea_pkg::word_t               key_low,
  input  logic                          write_enable,
  input  logic [xtea_pkg::KEY_IDX_W-1:0] write_index,
  input  xtea_pkg::word_t               write_data
);
  import xtea_pkg::*;

  localparam int unsigned CELLS = 2 * ROUNDS;

  key_t          key;
  beat_t         chain [0:CELLS];
  logic [CELLS-1:0] valids;
  logic          advance;

  xtea_key_regs u_key_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .key          (key)
  );

  assign chain[0] = '{valid: seed_valid, v0: seed_high, v1: seed_low};

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xtea_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .key     (key),
      .prev    (chain[i]),
      .cur     (chain[i+1])
    );
    assign valids[i] = chain[i+1].valid;
  end

  assign advance      = !(chain[CELLS].valid && result_stall);
  assign seed_stall   = !advance;
  assign result_valid = chain[CELLS].valid;
  assign key_high     = chain[CELLS].v0;
  assign key_low      = chain[CELLS].v1;

  // Beat count in flight grows by one when a seed enters and nothing leaves
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (seed_valid && !seed_stall && !(result_valid && !result_stall)) |=>
      ($countones(valids) == $past($countones(valids)) + 1))
    else $error("in-flight beat count did not grow on accept");

  // A stalled chain keeps every valid bit where it is
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(valids))
    else $error("cell chain moved while stalled");

  // No beat enters or leaves without a matching handshake
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!(seed_valid && !seed_stall) && !(result_valid && !result_stall)) |=>
      ($countones(valids) == $past($countones(valids))))
    else $error("beat count changed without a handshake");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for xtea_encrypt_block: 32-round XTEA encipher under random idling.
// Depends on rtl/xtea_pkg.sv and rtl/xtea_encrypt_block.sv.
module tb;
  import xtea_pkg::*;

  localparam int unsigned NUM_ROUNDS    = ROUNDS_DEFAULT;
  localparam int unsigned PIPE_DEPTH    = 2 * NUM_ROUNDS;
  localparam int unsigned PHASE_ITEMS   = 300;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct packed {
    word_t hi;
    word_t lo;
  } block_t;

  typedef word_t key_words_t [NUM_KEY_WORDS];

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  seed_valid = 1'b0;
  logic  seed_stall;
  word_t seed_high = '0;
  word_t seed_low = '0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  word_t key_high;
  word_t key_low;
  logic  write_enable = 1'b0;
  logic [KEY_IDX_W-1:0] write_index = '0;
  word_t write_data = '0;

  key_words_t  cipher_key = '{default: '0};
  block_t      plaintext_queue [$];
  block_t      ciphertext_queue [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  xtea_encrypt_block uut (
    .clk          (clk),
    .rst          (rst),
    .seed_valid   (seed_valid),
    .seed_stall   (seed_stall),
    .seed_high    (seed_high),
    .seed_low     (seed_low),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .key_high     (key_high),
    .key_low      (key_low),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always #4 clk = ~clk;

  function automatic block_t xtea_encipher(block_t plain);
    word_t v0, v1, sum;
    v0  = plain.hi;
    v1  = plain.lo;
    sum = '0;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      v0  += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + cipher_key[sum[1:0]]);
      sum += DELTA;
      // second half picks its key word from sum bits 12:11
      v1  += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + cipher_key[sum[12:11]]);
    end
    return '{hi: v0, lo: v1};
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic load_key(input key_words_t k);
    for (int i = 0; i < NUM_KEY_WORDS; i++) begin
      @(posedge clk);
      write_enable <= 1'b1;
      write_index  <= KEY_IDX_W'(i);
      write_data   <= k[i];
      cipher_key[i] = k[i];
    end
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // sampled at negedge so every beat handed over at the last edge is visible
  task automatic wait_idle();
    while (plaintext_queue.size() != 0 || seed_valid || ciphertext_queue.size() != 0)
      @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // seed driver: predicts each beat as it is taken, then offers the next one
  always @(posedge clk) begin : seed_driver
    block_t beat;
    if (rst) begin
      seed_valid <= 1'b0;
    end else begin
      if (seed_valid && !seed_stall)
        ciphertext_queue.push_back(xtea_encipher('{hi: seed_high, lo: seed_low}));
      if (!seed_valid || !seed_stall) begin
        if (plaintext_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat = plaintext_queue.pop_front();
          seed_high  <= beat.hi;
          seed_low   <= beat.lo;
          seed_valid <= 1'b1;
        end else begin
          seed_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : result_monitor
    block_t want;
    if (!rst && result_valid && !result_stall) begin
      if (ciphertext_queue.size() == 0) begin
        report_error($sformatf("unexpected result %h_%h", key_high, key_low));
      end else begin
        want = ciphertext_queue.pop_front();
        if (key_high !== want.hi)
          report_error($sformatf("key_high got %h want %h", key_high, want.hi));
        if (key_low !== want.lo)
          report_error($sformatf("key_low got %h want %h", key_low, want.lo));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 35;
    recv_idle_pct = 49;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed beats under the all-zero reset key
    plaintext_queue.push_back('{hi: 32'h0000_0000, lo: 32'h0000_0000});
    plaintext_queue.push_back('{hi: 32'hFFFF_FFFF, lo: 32'hFFFF_FFFF});
    plaintext_queue.push_back('{hi: 32'h0000_0000, lo: 32'hFFFF_FFFF});
    plaintext_queue.push_back('{hi: 32'hFFFF_FFFF, lo: 32'h0000_0000});
    plaintext_queue.push_back('{hi: 32'h8000_0000, lo: 32'h0000_0001});
    plaintext_queue.push_back('{hi: 32'h0000_0001, lo: 32'h8000_0000});
    plaintext_queue.push_back('{hi: 32'hAAAA_AAAA, lo: 32'h5555_5555});
    plaintext_queue.push_back('{hi: 32'h5555_5555, lo: 32'hAAAA_AAAA});
    plaintext_queue.push_back('{hi: 32'h0123_4567, lo: 32'h89AB_CDEF});
    plaintext_queue.push_back('{hi: 32'h4142_4344, lo: 32'h4546_4748});
    plaintext_queue.push_back('{hi: 32'h7FFF_FFFF, lo: 32'hFFFF_FFFE});
    plaintext_queue.push_back('{hi: 32'h0000_0010, lo: 32'h0000_0800});
    plaintext_queue.push_back('{hi: DELTA, lo: ~DELTA});
    plaintext_queue.push_back('{hi: 32'hFFFF_0000, lo: 32'h0000_FFFF});
    plaintext_queue.push_back('{hi: 32'h00FF_00FF, lo: 32'hFF00_FF00});
    plaintext_queue.push_back('{hi: 32'h0F0F_0F0F, lo: 32'hF0F0_F0F0});
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 35; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: load_key('{default: '1});
        1: load_key('{'0, '1, $urandom, $urandom});
        2: load_key('{32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F});
        5: load_key('{default: '0});
        default: load_key('{$urandom, $urandom, $urandom, $urandom});
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        plaintext_queue.push_back('{hi: random_word(), lo: random_word()});
      wait_idle();
    end

    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
